// ===== hw/rtl/adc_delta_block_encoder_assert.svh =====
// Assertion macros for the delta block encoder.
// ADBE_ASSERT checks a property on the rising clock edge, with reset as the disable.
// ADBE_ASSERT_ALWAYS checks a property on every rising clock edge, reset included.
`ifndef ADC_DELTA_BLOCK_ENCODER_ASSERT_SVH
`define ADC_DELTA_BLOCK_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
`define ADBE_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
`define ADBE_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define ADBE_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define ADBE_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif
`endif

// ===== hw/rtl/adbe_pkg.sv =====
`timescale 1ns / 1ps
package adbe_pkg;

  localparam int CHANNELS_DEFAULT = 64;
  localparam int LANES            = 4;
  localparam int MAX_WORDS        = 5;
  localparam int CNT_W            = 3;

  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_GROUP  = 1'b1;

  localparam logic [15:0] MARK_BIT  = 16'h8000;
  localparam logic [15:0] SMALL_POS = 16'h0007;
  localparam logic [15:0] SMALL_NEG = 16'hFFF9;
  localparam int          DIFF_BITS = 12;
  localparam int          NIB_BITS  = 4;

  typedef logic [15:0] word_t;

  typedef struct packed {
    logic opcode;
    logic ref_smp;
    logic last_group;
    logic odd;
  } ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             odd_next;
  } res_t;

endpackage

// ===== hw/rtl/adbe_lane.sv =====
`timescale 1ns / 1ps
module adbe_lane import adbe_pkg::*; #(
  parameter int GROUPS = CHANNELS_DEFAULT / LANES,
  parameter int GW     = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [GW-1:0] addr,
  input  word_t         raw,
  input  logic          ref_smp,
  output word_t         diff,
  output logic          is_small
);

  // one channel of every group; read old value and write new in the same edge
  word_t mem [GROUPS];
  word_t raw_q;
  word_t prev_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prev_q      <= mem[addr];
      mem[addr]   <= raw;
      raw_q       <= raw;
    end
  end

  always_comb begin
    diff     = ref_smp ? raw_q : word_t'(raw_q - prev_q);
    is_small = (diff <= SMALL_POS) || (diff >= SMALL_NEG);
  end

endmodule

// ===== hw/rtl/adbe_merge.sv =====
`timescale 1ns / 1ps
module adbe_merge import adbe_pkg::*; (
  input  ctrl_t                   ctrl,
  input  word_t                   header,
  input  logic [LANES-1:0][15:0]  diff,
  input  logic [LANES-1:0]        is_small,
  output logic [MAX_WORDS-1:0][15:0] words,
  output res_t                    res
);

  logic packed_grp;
  logic odd_after;
  logic pad;

  always_comb begin
    words      = '0;
    packed_grp = !ctrl.ref_smp && (&is_small);
    odd_after  = ctrl.odd ^ !packed_grp;
    pad        = ctrl.last_group && odd_after;
    res.count    = CNT_W'(1);
    res.odd_next = ctrl.odd;
    if (ctrl.opcode == OP_HEADER) begin
      words[0] = header;
    end else if (packed_grp) begin
      for (int i = 0; i < LANES; i++) begin
        words[0][i*NIB_BITS +: NIB_BITS] = diff[i][NIB_BITS-1:0];
      end
      res.count    = pad ? CNT_W'(2) : CNT_W'(1);
      res.odd_next = ctrl.last_group ? 1'b0 : odd_after;
    end else begin
      for (int i = 0; i < LANES; i++) begin
        words[i] = MARK_BIT | {4'h0, diff[i][DIFF_BITS-1:0]};
      end
      res.count    = pad ? CNT_W'(5) : CNT_W'(4);
      res.odd_next = ctrl.last_group ? 1'b0 : odd_after;
    end
  end

endmodule

// ===== hw/rtl/adc_delta_block_encoder.sv =====
`timescale 1ns / 1ps
// Stage 1 takes a new item while the output buffer still drains the previous item's words.
// Words per item: header item or packed group one, packed group with pad two,
//   unpacked group four, five with pad; the one-word output port sets the rate.
// Reset (rst, sync, active high) clears group index, unpacked parity and valids;
//   the previous-sample memory is not cleared and holds garbage until written.
module adc_delta_block_encoder import adbe_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  logic  opcode,
  input  word_t header_word,
  input  word_t adc_first,
  input  word_t adc_second,
  input  word_t adc_third,
  input  word_t adc_fourth,
  input  logic  reference_sample,
  output logic  out_valid,
  input  logic  out_stall,
  output word_t out_word,
  output logic  last_word
);

`include "adc_delta_block_encoder_assert.svh"

  localparam int GROUPS = CHANNELS / LANES;
  localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  // ---------------------------------------------------------------
  // Stage 1: item capture. The lane memories are read and written
  // at the accept edge of a group item, so stage 1 always holds its diff operands.
  // ---------------------------------------------------------------
  logic           accept;
  logic           s1_valid;
  logic           s1_move;
  logic           s1_opcode;
  logic           s1_ref;
  logic           s1_last_group;
  word_t          s1_header;
  logic [GW-1:0]  gidx;
  logic           odd;
  logic           acc_last_group;

  logic [LANES-1:0][15:0] lane_raw;
  logic [LANES-1:0][15:0] lane_diff;
  logic [LANES-1:0]       lane_small;

  assign lane_raw[0] = adc_first;
  assign lane_raw[1] = adc_second;
  assign lane_raw[2] = adc_third;
  assign lane_raw[3] = adc_fourth;

  // ---------------------------------------------------------------
  // Stage 2: output buffer, drained one word per cycle while out_stall is low.
  // ---------------------------------------------------------------
  word_t              obuf [MAX_WORDS];
  logic [CNT_W-1:0]   ocnt;
  logic [CNT_W-1:0]   oidx;
  logic               take;
  logic               done;
  logic               free;

  logic [MAX_WORDS-1:0][15:0] m_words;
  res_t                       m_res;
  ctrl_t                      m_ctrl;

  assign out_word  = obuf[oidx];
  assign last_word = (oidx == ocnt - CNT_W'(1));
  assign take      = out_valid && !out_stall;
  assign done      = take && last_word;
  assign free      = !out_valid || done;
  assign s1_move   = s1_valid && free;
  assign in_stall  = s1_valid && !free;
  assign accept    = in_valid && !in_stall;

  assign acc_last_group = (gidx == GW'(GROUPS - 1));

  genvar l;
  generate
    for (l = 0; l < LANES; l++) begin : g_lane
      adbe_lane #(
        .GROUPS (GROUPS),
        .GW     (GW)
      ) u_lane (
        .clk      (clk),
        .wr_en    (accept && (opcode == OP_GROUP)),
        .addr     (gidx),
        .raw      (lane_raw[l]),
        .ref_smp  (s1_ref),
        .diff     (lane_diff[l]),
        .is_small (lane_small[l])
      );
    end
  endgenerate

  assign m_ctrl = '{opcode: s1_opcode, ref_smp: s1_ref,
                    last_group: s1_last_group, odd: odd};

  adbe_merge u_merge (
    .ctrl     (m_ctrl),
    .header   (s1_header),
    .diff     (lane_diff),
    .is_small (lane_small),
    .words    (m_words),
    .res      (m_res)
  );

  // stage 1 control and group counter; group index advances at accept of a group item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      gidx     <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (accept && (opcode == OP_GROUP)) begin
        gidx <= acc_last_group ? '0 : gidx + GW'(1);
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_opcode     <= opcode;
      s1_ref        <= reference_sample;
      s1_header     <= header_word;
      s1_last_group <= acc_last_group;
    end
  end

  // output buffer control; unpacked parity moves with the item into the buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      oidx      <= '0;
      ocnt      <= CNT_W'(1);
      odd       <= 1'b0;
    end else begin
      if (s1_move) begin
        out_valid <= 1'b1;
        oidx      <= '0;
        ocnt      <= m_res.count;
        odd       <= m_res.odd_next;
      end else if (done) begin
        out_valid <= 1'b0;
      end else if (take) begin
        oidx <= oidx + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      for (int i = 0; i < MAX_WORDS; i++) begin
        obuf[i] <= m_words[i];
      end
    end
  end

  `ADBE_ASSERT(a_idx_in_range, clk, rst, out_valid |-> (oidx < ocnt), "word index beyond count")
  `ADBE_ASSERT(a_cnt_max, clk, rst, out_valid |-> (ocnt <= CNT_W'(MAX_WORDS)), "bad word count")
  `ADBE_ASSERT(a_gidx_range, clk, rst, gidx <= GW'(GROUPS - 1), "group index out of range")
  `ADBE_ASSERT_ALWAYS(a_stall_pending, clk, in_stall |-> s1_valid, "stall with empty stage")

endmodule

// ===== verif/tb_adc_delta_block_encoder.sv =====
`timescale 1ns / 1ps
module tb_adc_delta_block_encoder;
  import adbe_pkg::*;

  localparam int     CH         = CHANNELS_DEFAULT;
  localparam int     GROUPS     = CH / LANES;
  localparam int     IDLE_PCT   = 15;
  localparam int     RAND_ITEMS = 205;
  localparam int     DRAIN_CYC  = 20;      // margin left after the queues have emptied
  localparam int     WDOG_LIMIT = 2000;    // cycles with no handshake on either side
  localparam word_t  DIFF_MASK  = word_t'((1 << DIFF_BITS) - 1);

  // one input item, every field kept even when the opcode ignores it
  typedef struct {
    logic  opcode;
    word_t header;
    word_t adc [LANES];
    logic  ref_smp;
  } stim_t;

  // one output word as the block should emit it
  typedef struct packed {
    word_t word;
    logic  last;
  } enc_word_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  logic  opcode = OP_HEADER;
  word_t header_word = '0;
  word_t adc_first = '0;
  word_t adc_second = '0;
  word_t adc_third = '0;
  word_t adc_fourth = '0;
  logic  reference_sample = 1'b0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t out_word;
  logic  last_word;

  stim_t     pending_items [$];
  enc_word_t expected_words [$];
  stim_t     cur;

  // predictor state: last raw word per channel, group position, unpacked parity
  word_t prev_raw [CH];
  int    grp_idx = 0;
  logic  odd_parity = 1'b0;

  // stimulus-side shadow, used only to steer deltas and to avoid reading
  // channels that have never been written since reset
  word_t gen_raw [CH];
  bit    gen_ok [CH];
  int    gen_grp = 0;

  int err_cnt = 0;
  int items_taken = 0;
  int n_hdr = 0;
  int n_packed = 0;
  int n_unpacked = 0;
  int n_pad = 0;
  int words_seen = 0;
  int wdog = 0;

  // window of accepted items in which neither side idles
  wire calm = (items_taken >= 120) && (items_taken < 180);

  always #4 clk = ~clk;

  adc_delta_block_encoder #(.CHANNELS(CH)) uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .opcode           (opcode),
    .header_word      (header_word),
    .adc_first        (adc_first),
    .adc_second       (adc_second),
    .adc_third        (adc_third),
    .adc_fourth       (adc_fourth),
    .reference_sample (reference_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_word         (out_word),
    .last_word        (last_word)
  );

  // Append one predicted word at the tail of the expected stream.
  task automatic add_expected(input word_t wd, input logic lst);
    enc_word_t e;
    e.word = wd;
    e.last = lst;
    expected_words.insert(expected_words.size(), e);
  endtask

  // Predict the words caused by one accepted item and queue them in order.
  task automatic encode_item(input stim_t it);
    word_t d [LANES];
    word_t w [MAX_WORDS];
    int    n;
    int    base;
    logic  fits;
    logic  last_grp;
    n = 0;
    if (it.opcode == OP_HEADER) begin
      // header passes through and leaves all group state alone
      add_expected(it.header, 1'b1);
      n_hdr++;
      return;
    end
    fits = 1'b1;
    base = grp_idx * LANES;
    for (int i = 0; i < LANES; i++) begin
      d[i] = it.ref_smp ? it.adc[i] : word_t'(it.adc[i] - prev_raw[base + i]);
      prev_raw[base + i] = it.adc[i];
      // signed -7..7 wraps to 0..7 or FFF9..FFFF
      if (!(d[i] <= SMALL_POS || d[i] >= SMALL_NEG))
        fits = 1'b0;
    end
    if (!it.ref_smp && fits) begin
      w[n++] = {d[3][NIB_BITS-1:0], d[2][NIB_BITS-1:0], d[1][NIB_BITS-1:0], d[0][NIB_BITS-1:0]};
      n_packed++;
    end else begin
      // reference groups and groups that do not fit go out as four marked 12-bit words
      for (int i = 0; i < LANES; i++)
        w[n++] = (d[i] & DIFF_MASK) | MARK_BIT;
      odd_parity ^= 1'b1;
      n_unpacked++;
    end
    last_grp = (grp_idx == GROUPS - 1);
    if (last_grp) begin
      // a pad word follows when the sample held an odd number of unpacked groups
      if (odd_parity) begin
        w[n++] = '0;
        n_pad++;
      end
      grp_idx = 0;
      odd_parity = 1'b0;
    end else begin
      grp_idx++;
    end
    for (int k = 0; k < n; k++)
      add_expected(w[k], (k == n - 1));
  endtask

  // Queue one ADC group; a delta group that would touch an unwritten channel
  // is turned into a reference group.
  task automatic queue_group(input word_t a0, input word_t a1, input word_t a2,
                             input word_t a3, input logic r);
    stim_t it;
    int    base;
    base = gen_grp * LANES;
    it.opcode = OP_GROUP;
    it.header = word_t'($urandom);
    it.adc[0] = a0;
    it.adc[1] = a1;
    it.adc[2] = a2;
    it.adc[3] = a3;
    it.ref_smp = r;
    for (int i = 0; i < LANES; i++) begin
      if (!gen_ok[base + i])
        it.ref_smp = 1'b1;
    end
    for (int i = 0; i < LANES; i++) begin
      gen_raw[base + i] = it.adc[i];
      gen_ok[base + i] = 1'b1;
    end
    gen_grp = (gen_grp + 1) % GROUPS;
    pending_items.insert(pending_items.size(), it);
  endtask

  // delta group built on the current shadow values, wrapping at 16 bits
  task automatic queue_delta(input int d0, input int d1, input int d2, input int d3);
    int base;
    base = gen_grp * LANES;
    queue_group(word_t'(gen_raw[base] + d0), word_t'(gen_raw[base + 1] + d1),
                word_t'(gen_raw[base + 2] + d2), word_t'(gen_raw[base + 3] + d3), 1'b0);
  endtask

  // header item; the ADC fields carry junk that the block must ignore
  task automatic queue_header(input word_t h);
    stim_t it;
    it.opcode = OP_HEADER;
    it.header = h;
    for (int i = 0; i < LANES; i++)
      it.adc[i] = word_t'($urandom);
    it.ref_smp = 1'($urandom);
    pending_items.insert(pending_items.size(), it);
  endtask

  // Driver: holds the payload while stalled, predicts on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_item(cur);
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          cur = pending_items.pop_front();
          opcode           <= cur.opcode;
          header_word      <= cur.header;
          adc_first        <= cur.adc[0];
          adc_second       <= cur.adc[1];
          adc_third        <= cur.adc[2];
          adc_fourth       <= cur.adc[3];
          reference_sample <= cur.ref_smp;
          in_valid         <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every accepted word is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          $error("unexpected output word %h (last %b)", out_word, last_word);
          err_cnt++;
        end else begin
          enc_word_t e;
          e = expected_words.pop_front();
          if (out_word !== e.word) begin
            $error("out_word: expected %h, got %h", e.word, out_word);
            err_cnt++;
          end
          if (last_word !== e.last) begin
            $error("last_word: expected %b, got %b", e.last, last_word);
            err_cnt++;
          end
        end
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Watchdog: a hung handshake on both sides ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      wdog <= 0;
    end else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int k;
    int lane;
    int d [LANES];
    for (int c = 0; c < CH; c++) begin
      prev_raw[c] = '0;
      gen_raw[c] = '0;
      gen_ok[c] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: header extremes, a reference sample with a header in the
    // middle, then deltas around the packing threshold and across the wrap.
    queue_header(16'h0000);
    queue_header(16'hFFFF);
    queue_group(16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 1'b1);
    for (int g = 1; g < GROUPS; g++) begin
      if (g == GROUPS / 2)
        queue_header(16'hA55A);
      queue_group(word_t'($urandom), word_t'($urandom), word_t'($urandom),
                  word_t'($urandom), 1'b1);
    end
    queue_delta(7, -7, 1, 1);        // fits; ch3 crosses the signed 16-bit boundary
    queue_delta(8, 0, 0, 0);         // just over on the positive side
    queue_delta(-8, 0, 0, 0);        // just over on the negative side
    queue_delta(-7, 7, -1, 0);       // fits at both edges
    queue_delta(32768, 0, 0, 0);     // most negative 16-bit difference
    queue_delta(0, 0, 0, 0);

    // hold off until everything in flight has drained
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_words.size() != 0);

    // Random: mostly well-formed samples with small deltas, plus boundary
    // lanes, raw noise, reference groups and stray headers.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      k = $urandom_range(99);
      if (k < 10) begin
        queue_header(word_t'($urandom));
      end else if (k < 18) begin
        queue_group(word_t'($urandom), word_t'($urandom), word_t'($urandom),
                    word_t'($urandom), 1'b1);
      end else if (k < 65) begin
        for (int i = 0; i < LANES; i++)
          d[i] = int'($urandom_range(14)) - 7;
        queue_delta(d[0], d[1], d[2], d[3]);
      end else if (k < 80) begin
        for (int i = 0; i < LANES; i++)
          d[i] = int'($urandom_range(14)) - 7;
        lane = $urandom_range(LANES - 1);
        case ($urandom_range(3))
          0: d[lane] = 7;
          1: d[lane] = -7;
          2: d[lane] = 8;
          default: d[lane] = -8;
        endcase
        queue_delta(d[0], d[1], d[2], d[3]);
      end else begin
        queue_group(word_t'($urandom), word_t'($urandom), word_t'($urandom),
                    word_t'($urandom), 1'b0);
      end
      // keep the queue short so idling lands on all phases of the block
      while (pending_items.size() > 4)
        @(negedge clk);
    end

    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_words.size() != 0);
    repeat (DRAIN_CYC) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d predicted words never arrived", expected_words.size());
      err_cnt++;
    end

    $display("covered %0d items: %0d headers, %0d packed and %0d unpacked groups, %0d pads",
             items_taken, n_hdr, n_packed, n_unpacked, n_pad);
    $display("checked %0d output words, %0d errors", words_seen, err_cnt);
    if (err_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
